// ----- sv/rmsb_pkg.sv -----
// ----------------------------------------------------------------------------
// rmsb_pkg
// Types and constants shared by the robot mode sequencer with buzzer.
// ----------------------------------------------------------------------------
package rmsb_pkg;

  // operating modes, encoding as seen on the command and result beats
  typedef enum logic [2:0] {
    MODE_IDLE   = 3'd0,
    MODE_LINE   = 3'd1,
    MODE_CHECK  = 3'd2,
    MODE_OBST   = 3'd3,
    MODE_CHARGE = 3'd4,
    MODE_ESTOP  = 3'd5
  } mode_e;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_DWELL_TICKS      = 2'd0,
    CFG_CHECK_BEEP_TICKS = 2'd1,
    CFG_CHARGE_BEEP_TICKS = 2'd2,
    CFG_TRANS_BEEP_TICKS = 2'd3
  } cfg_idx_e;

  localparam int unsigned DwellBits = 10;
  localparam int unsigned BeepCfgBits = 8;
  localparam int unsigned BeepCntBits = 14;
  localparam int unsigned CfgDataBits = 10;
  localparam int unsigned TdataBits = 16;

  localparam logic [BeepCntBits-1:0] EstopBeep = 14'd9999;
  localparam logic [DwellBits-1:0]   DwellMax = 10'h3FF;

  // register reset values
  localparam logic [DwellBits-1:0]   DwellTicksRst = 10'd60;
  localparam logic [BeepCfgBits-1:0] CheckBeepRst = 8'd4;
  localparam logic [BeepCfgBits-1:0] ChargeBeepRst = 8'd6;
  localparam logic [BeepCfgBits-1:0] TransBeepRst = 8'd2;

  typedef struct packed {
    logic [DwellBits-1:0]   dwell_ticks;
    logic [BeepCfgBits-1:0] check_beep;
    logic [BeepCfgBits-1:0] charge_beep;
    logic [BeepCfgBits-1:0] trans_beep;
  } cfg_t;

  // control state apart from the station number
  typedef struct packed {
    mode_e                  mode;
    mode_e                  prior_mode;
    logic [DwellBits-1:0]   dwell_count;
    logic                   charging;
    logic [BeepCntBits-1:0] beep_count;
    logic                   beep_active;
  } ctrl_t;

  typedef struct packed {
    logic       command_valid;
    logic [2:0] target_mode;
    logic [7:0] next_station;
    logic       obstacle_seen;
  } item_t;

  typedef struct packed {
    mode_e      mode_now;
    logic       stop_command;
    logic       safety_stop;
    logic       buzzer_on;
    logic [7:0] station_now;
    logic       charge_on;
  } result_t;

endpackage

// ----- sv/rmsb_step.sv -----
// ----------------------------------------------------------------------------
// rmsb_step
// One control tick: command handling, mode step and buzzer update.
// ----------------------------------------------------------------------------
module rmsb_step #(
  parameter int unsigned STATION_BITS = 8
) (
  input  rmsb_pkg::cfg_t            cfg_i,
  input  rmsb_pkg::ctrl_t           ctrl_i,
  input  logic [STATION_BITS-1:0]   station_i,
  input  rmsb_pkg::item_t           item_i,
  output rmsb_pkg::ctrl_t           ctrl_o,
  output logic [STATION_BITS-1:0]   station_o,
  output rmsb_pkg::result_t         result_o
);

  rmsb_pkg::ctrl_t         cmd_st;
  logic [STATION_BITS-1:0] cmd_station;
  logic                    cmd_take;
  rmsb_pkg::mode_e         target;
  rmsb_pkg::ctrl_t         step_st;
  logic                    stop;
  logic                    safety;
  logic                    buzz;

  assign target = rmsb_pkg::mode_e'(item_i.target_mode);

  // a command is taken if in range, not blocked by estop, and a real change
  assign cmd_take = item_i.command_valid
                 && (item_i.target_mode <= 3'(rmsb_pkg::MODE_ESTOP))
                 && !((ctrl_i.mode == rmsb_pkg::MODE_ESTOP)
                      && (item_i.target_mode != 3'(rmsb_pkg::MODE_IDLE)))
                 && (item_i.target_mode != 3'(ctrl_i.mode));

  // command handling
  always_comb begin
    cmd_st      = ctrl_i;
    cmd_station = station_i;
    if (cmd_take) begin
      cmd_st.prior_mode  = ctrl_i.mode;
      cmd_st.mode        = target;
      cmd_st.beep_active = 1'b1;
      case (target)
        rmsb_pkg::MODE_ESTOP: cmd_st.beep_count = rmsb_pkg::EstopBeep;
        rmsb_pkg::MODE_CHECK: begin
          cmd_st.beep_count = rmsb_pkg::BeepCntBits'(cfg_i.check_beep);
          cmd_station       = STATION_BITS'(item_i.next_station);
        end
        rmsb_pkg::MODE_CHARGE: begin
          cmd_st.beep_count = rmsb_pkg::BeepCntBits'(cfg_i.charge_beep);
          cmd_st.charging   = 1'b1;
        end
        default: cmd_st.beep_count = rmsb_pkg::BeepCntBits'(cfg_i.trans_beep);
      endcase
    end
  end

  // mode step
  always_comb begin
    step_st = cmd_st;
    stop    = 1'b0;
    safety  = 1'b0;
    unique case (cmd_st.mode)
      rmsb_pkg::MODE_IDLE: begin
        stop             = 1'b1;
        step_st.charging = 1'b0;
      end
      rmsb_pkg::MODE_CHECK: begin
        stop = 1'b1;
        if (cmd_st.dwell_count < rmsb_pkg::DwellMax) begin
          step_st.dwell_count = cmd_st.dwell_count + 1'b1;
        end
        if (step_st.dwell_count >= cfg_i.dwell_ticks) begin
          step_st.dwell_count = '0;
          step_st.mode        = rmsb_pkg::MODE_LINE;
        end
      end
      rmsb_pkg::MODE_OBST: begin
        stop = 1'b1;
        if (!item_i.obstacle_seen) begin
          step_st.mode = (cmd_st.prior_mode == rmsb_pkg::MODE_LINE) ?
                         rmsb_pkg::MODE_LINE : rmsb_pkg::MODE_IDLE;
        end else begin
          step_st.beep_active = 1'b1;
          if (cmd_st.beep_count == '0) begin
            step_st.beep_count = rmsb_pkg::BeepCntBits'(cfg_i.trans_beep);
          end
        end
      end
      rmsb_pkg::MODE_CHARGE: stop = 1'b1;
      rmsb_pkg::MODE_ESTOP: begin
        stop   = 1'b1;
        safety = 1'b1;
      end
      default: ;
    endcase
  end

  // buzzer: held on in estop, otherwise toggles while counting down
  always_comb begin
    ctrl_o = step_st;
    buzz   = 1'b0;
    if (step_st.beep_active) begin
      if (step_st.beep_count != '0) begin
        if (cmd_st.mode == rmsb_pkg::MODE_ESTOP) begin
          buzz = 1'b1;
        end else begin
          buzz              = ~step_st.beep_count[0];
          ctrl_o.beep_count = step_st.beep_count - 1'b1;
        end
      end else begin
        ctrl_o.beep_active = 1'b0;
      end
    end
  end

  assign station_o = cmd_station;

  // result of this tick
  always_comb begin
    result_o.mode_now     = step_st.mode;
    result_o.stop_command = stop;
    result_o.safety_stop  = safety;
    result_o.buzzer_on    = buzz;
    result_o.station_now  = 8'(cmd_station);
    result_o.charge_on    = step_st.charging;
  end

endmodule

// ----- sv/robot_mode_sequencer_with_buzzer_unit.sv -----
// ----------------------------------------------------------------------------
// robot_mode_sequencer_with_buzzer_unit
// Robot mode sequencer: six modes, checkpoint dwell, obstacle fallback, buzzer.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake             | payload
//  s_axis    | in        | s_axis_tvalid/tready  | tick item (tuser: command_valid)
//  m_axis    | out       | m_axis_tvalid/tready  | tick result
//  cfg       | in        | cfg_valid_i/ready_o   | register index, write data
//
//  one beat per cycle while s_axis_tready is high; each result is registered
//  the step is pure logic from the input beat to the result or skid register
//  a two-entry output (result register plus skid) keeps s_axis_tready high while
//  one result waits; tready drops only when both are full
//  cfg is always ready; reset loads the default register values and idle mode
// ----------------------------------------------------------------------------
module robot_mode_sequencer_with_buzzer_unit #(
  parameter int unsigned STATION_BITS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // tick items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [2:0] target_mode, [10:3] next_station, [11] obstacle_seen, [15:12] zero
  input  logic [15:0] s_axis_tdata,
  // [0] command_valid
  input  logic        s_axis_tuser,
  // results
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [2:0] mode_now, [3] stop_command, [4] safety_stop, [5] buzzer_on,
  // [13:6] station_now, [14] charge_on, [15] zero
  output logic [15:0] m_axis_tdata,
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [9:0]  cfg_data_i
);

  rmsb_pkg::cfg_t          cfg_q;
  rmsb_pkg::ctrl_t         ctrl_q, ctrl_d;
  logic [STATION_BITS-1:0] station_q, station_d;
  rmsb_pkg::item_t         item;
  rmsb_pkg::result_t       result;
  logic [15:0]             result_data;
  logic                    in_fire;
  logic                    out_fire;
  logic                    out_valid_q;
  logic [15:0]             out_data_q;
  logic                    skid_valid_q;
  logic [15:0]             skid_data_q;

  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dwell_ticks <= rmsb_pkg::DwellTicksRst;
      cfg_q.check_beep  <= rmsb_pkg::CheckBeepRst;
      cfg_q.charge_beep <= rmsb_pkg::ChargeBeepRst;
      cfg_q.trans_beep  <= rmsb_pkg::TransBeepRst;
    end else if (cfg_valid_i) begin
      unique case (rmsb_pkg::cfg_idx_e'(cfg_index_i))
        rmsb_pkg::CFG_DWELL_TICKS:       cfg_q.dwell_ticks <= cfg_data_i;
        rmsb_pkg::CFG_CHECK_BEEP_TICKS:  cfg_q.check_beep  <= cfg_data_i[7:0];
        rmsb_pkg::CFG_CHARGE_BEEP_TICKS: cfg_q.charge_beep <= cfg_data_i[7:0];
        rmsb_pkg::CFG_TRANS_BEEP_TICKS:  cfg_q.trans_beep  <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // unpack the input beat
  always_comb begin
    item.command_valid = s_axis_tuser;
    item.target_mode   = s_axis_tdata[2:0];
    item.next_station  = s_axis_tdata[10:3];
    item.obstacle_seen = s_axis_tdata[11];
  end

  rmsb_step #(
    .STATION_BITS(STATION_BITS)
  ) u_step (
    .cfg_i     (cfg_q),
    .ctrl_i    (ctrl_q),
    .station_i (station_q),
    .item_i    (item),
    .ctrl_o    (ctrl_d),
    .station_o (station_d),
    .result_o  (result)
  );

  assign result_data = {1'b0, result.charge_on, result.station_now,
                        result.buzzer_on, result.safety_stop, result.stop_command,
                        3'(result.mode_now)};

  assign s_axis_tready = !skid_valid_q;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_fire      = out_valid_q && m_axis_tready;

  // sequencer state advances on every accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q.mode        <= rmsb_pkg::MODE_IDLE;
      ctrl_q.prior_mode  <= rmsb_pkg::MODE_IDLE;
      ctrl_q.dwell_count <= '0;
      ctrl_q.charging    <= 1'b0;
      ctrl_q.beep_count  <= '0;
      ctrl_q.beep_active <= 1'b0;
      station_q          <= '0;
    end else if (in_fire) begin
      ctrl_q    <= ctrl_d;
      station_q <= station_d;
    end
  end

  // output register and skid control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (out_fire) begin
        if (skid_valid_q) begin
          skid_valid_q <= 1'b0;
        end else begin
          out_valid_q <= in_fire;
        end
      end else if (in_fire) begin
        if (out_valid_q) begin
          skid_valid_q <= 1'b1;
        end else begin
          out_valid_q <= 1'b1;
        end
      end
    end
  end

  // output and skid payload
  always_ff @(posedge clk_i) begin
    if (out_fire) begin
      if (skid_valid_q) begin
        out_data_q <= skid_data_q;
      end else if (in_fire) begin
        out_data_q <= result_data;
      end
    end else if (in_fire) begin
      if (out_valid_q) begin
        skid_data_q <= result_data;
      end else begin
        out_data_q <= result_data;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ----- sv/rmsb_checker.sv -----
// ----------------------------------------------------------------------------
// rmsb_checker
// Port-level checks for the robot mode sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module rmsb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);

  // a stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  // a safety stop is always a stop issued in estop
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[4] |->
      m_axis_tdata[3] && (m_axis_tdata[2:0] == 3'(rmsb_pkg::MODE_ESTOP)))
    else $error("safety stop without stop or outside estop");

  // only line following runs without a stop command
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[3] |->
      (m_axis_tdata[2:0] == 3'(rmsb_pkg::MODE_LINE)))
    else $error("missing stop outside line following");

  // a result only appears after an input beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready))
    else $error("result beat without an input beat");

endmodule

bind robot_mode_sequencer_with_buzzer_unit rmsb_checker u_rmsb_checker (.*);

// ----- tb/robot_mode_sequencer_with_buzzer_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// robot_mode_sequencer_with_buzzer_unit_tb
// Self-checking bench for the robot mode sequencer with buzzer. A directed
// run of ticks walks every mode and command corner. Random mission fragments
// then follow: checkpoint visits, obstacle episodes, charging, emergency stop
// and loose noise. Each phase sets the registers and the idling mix anew.
// A local mode sequencer predicts every result beat from the accepted ticks.
// ----------------------------------------------------------------------------
module robot_mode_sequencer_with_buzzer_unit_tb;

  localparam int unsigned CycleLimit = 200000;

  // dut connections
  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [15:0]           s_axis_tdata = '0;
  logic                  s_axis_tuser = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [15:0]           m_axis_tdata;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  rmsb_pkg::cfg_idx_e    cfg_index = rmsb_pkg::CFG_DWELL_TICKS;
  logic [9:0]            cfg_data_i = '0;

  // stimulus and scoreboard storage
  rmsb_pkg::item_t       pending_ticks[$];
  rmsb_pkg::result_t     expected_results[$];
  rmsb_pkg::item_t       drv_tick;
  rmsb_pkg::item_t       mon_tick;
  rmsb_pkg::result_t     mon_result;
  rmsb_pkg::result_t     want;
  logic                  tick_beat_done = 1'b0;
  int                    send_idle_pct = 0;
  int                    recv_stall_pct = 0;
  int                    queued_ticks = 0;
  int                    cfg_writes = 0;
  int                    error_count = 0;
  int                    result_count = 0;
  int unsigned           cycle_count = 0;

  // shadow registers and sequencer state
  logic [rmsb_pkg::DwellBits-1:0]   sh_dwell_ticks;
  logic [rmsb_pkg::BeepCfgBits-1:0] sh_check_beep;
  logic [rmsb_pkg::BeepCfgBits-1:0] sh_charge_beep;
  logic [rmsb_pkg::BeepCfgBits-1:0] sh_trans_beep;
  rmsb_pkg::mode_e                  sq_mode;
  rmsb_pkg::mode_e                  sq_prior;
  logic [7:0]                       sq_station;
  logic [rmsb_pkg::DwellBits-1:0]   sq_dwell;
  logic                             sq_charging;
  logic [rmsb_pkg::BeepCntBits-1:0] sq_beep;
  logic                             sq_beep_on;

  robot_mode_sequencer_with_buzzer_unit uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data_i)
  );

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // power-on state of the sequencer
  initial begin
    sh_dwell_ticks = rmsb_pkg::DwellTicksRst;
    sh_check_beep  = rmsb_pkg::CheckBeepRst;
    sh_charge_beep = rmsb_pkg::ChargeBeepRst;
    sh_trans_beep  = rmsb_pkg::TransBeepRst;
    sq_mode        = rmsb_pkg::MODE_IDLE;
    sq_prior       = rmsb_pkg::MODE_IDLE;
    sq_station     = '0;
    sq_dwell       = '0;
    sq_charging    = 1'b0;
    sq_beep        = '0;
    sq_beep_on     = 1'b0;
  end

  // one control tick: command, mode step, buzzer
  function automatic rmsb_pkg::result_t sequencer_tick(rmsb_pkg::item_t it);
    rmsb_pkg::result_t r;
    rmsb_pkg::mode_e   seen;
    logic              stop;
    logic              safety;
    logic              buzz;
    stop   = 1'b0;
    safety = 1'b0;
    buzz   = 1'b0;

    // command; estop only yields to idle, out-of-range targets are dropped
    if (it.command_valid && it.target_mode <= rmsb_pkg::MODE_ESTOP &&
        !(sq_mode == rmsb_pkg::MODE_ESTOP && it.target_mode != rmsb_pkg::MODE_IDLE) &&
        sq_mode != it.target_mode) begin
      sq_prior   = sq_mode;
      sq_mode    = rmsb_pkg::mode_e'(it.target_mode);
      sq_beep_on = 1'b1;
      case (sq_mode)
        rmsb_pkg::MODE_ESTOP: begin
          sq_beep = rmsb_pkg::EstopBeep;
        end
        rmsb_pkg::MODE_CHECK: begin
          sq_beep    = rmsb_pkg::BeepCntBits'(sh_check_beep);
          sq_station = it.next_station;
        end
        rmsb_pkg::MODE_CHARGE: begin
          sq_beep     = rmsb_pkg::BeepCntBits'(sh_charge_beep);
          sq_charging = 1'b1;
        end
        default: begin
          sq_beep = rmsb_pkg::BeepCntBits'(sh_trans_beep);
        end
      endcase
    end

    // mode step
    seen = sq_mode;
    case (seen)
      rmsb_pkg::MODE_IDLE: begin
        stop        = 1'b1;
        sq_charging = 1'b0;
      end
      rmsb_pkg::MODE_CHECK: begin
        // dwell count survives re-entry, only a finished dwell clears it
        if (sq_dwell < rmsb_pkg::DwellMax) sq_dwell = sq_dwell + 1'b1;
        stop = 1'b1;
        if (sq_dwell >= sh_dwell_ticks) begin
          sq_dwell = '0;
          sq_mode  = rmsb_pkg::MODE_LINE;
        end
      end
      rmsb_pkg::MODE_OBST: begin
        stop = 1'b1;
        if (!it.obstacle_seen) begin
          sq_mode = (sq_prior == rmsb_pkg::MODE_LINE) ? rmsb_pkg::MODE_LINE
                                                       : rmsb_pkg::MODE_IDLE;
        end else begin
          sq_beep_on = 1'b1;
          if (sq_beep == '0) sq_beep = rmsb_pkg::BeepCntBits'(sh_trans_beep);
        end
      end
      rmsb_pkg::MODE_CHARGE: begin
        stop = 1'b1;
      end
      rmsb_pkg::MODE_ESTOP: begin
        stop   = 1'b1;
        safety = 1'b1;
      end
      default: begin
      end
    endcase

    // buzzer: held on in estop, else on for even counts while counting down
    if (sq_beep_on) begin
      if (sq_beep != '0) begin
        if (seen == rmsb_pkg::MODE_ESTOP) begin
          buzz = 1'b1;
        end else begin
          buzz    = ~sq_beep[0];
          sq_beep = sq_beep - 1'b1;
        end
      end else begin
        sq_beep_on = 1'b0;
      end
    end

    r.mode_now     = sq_mode;
    r.stop_command = stop;
    r.safety_stop  = safety;
    r.buzzer_on    = buzz;
    r.station_now  = sq_station;
    r.charge_on    = sq_charging;
    return r;
  endfunction

  task automatic report_mismatch(string field, int got, int exp_val);
    $display("[%0t] result %0d: %s got %0d, expected %0d", $realtime, result_count,
             field, got, exp_val);
    error_count++;
  endtask

  // tick driver
  always @(negedge clk_i) begin
    if (!s_axis_tvalid || tick_beat_done) begin
      if (pending_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        drv_tick = pending_ticks.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, drv_tick.obstacle_seen, drv_tick.next_station,
                          drv_tick.target_mode};
        s_axis_tuser  <= drv_tick.command_valid;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // result receiver back-pressure
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // monitor: register writes, accepted ticks, result beats
  always @(posedge clk_i) begin
    tick_beat_done <= s_axis_tvalid && s_axis_tready;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index)
          rmsb_pkg::CFG_DWELL_TICKS:       sh_dwell_ticks = cfg_data_i;
          rmsb_pkg::CFG_CHECK_BEEP_TICKS:  sh_check_beep  = cfg_data_i[7:0];
          rmsb_pkg::CFG_CHARGE_BEEP_TICKS: sh_charge_beep = cfg_data_i[7:0];
          rmsb_pkg::CFG_TRANS_BEEP_TICKS:  sh_trans_beep  = cfg_data_i[7:0];
          default: ;
        endcase
        cfg_writes++;
      end

      // compare before queuing the new tick so a stray beat is never masked
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          $display("[%0t] result beat with no tick outstanding, tdata %h", $realtime,
                   m_axis_tdata);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          mon_result.mode_now     = rmsb_pkg::mode_e'(m_axis_tdata[2:0]);
          mon_result.stop_command = m_axis_tdata[3];
          mon_result.safety_stop  = m_axis_tdata[4];
          mon_result.buzzer_on    = m_axis_tdata[5];
          mon_result.station_now  = m_axis_tdata[13:6];
          mon_result.charge_on    = m_axis_tdata[14];
          if (mon_result.mode_now != want.mode_now)
            report_mismatch("mode_now", mon_result.mode_now, want.mode_now);
          if (mon_result.stop_command != want.stop_command)
            report_mismatch("stop_command", mon_result.stop_command, want.stop_command);
          if (mon_result.safety_stop != want.safety_stop)
            report_mismatch("safety_stop", mon_result.safety_stop, want.safety_stop);
          if (mon_result.buzzer_on != want.buzzer_on)
            report_mismatch("buzzer_on", mon_result.buzzer_on, want.buzzer_on);
          if (mon_result.station_now != want.station_now)
            report_mismatch("station_now", mon_result.station_now, want.station_now);
          if (mon_result.charge_on != want.charge_on)
            report_mismatch("charge_on", mon_result.charge_on, want.charge_on);
        end
        result_count++;
      end

      if (s_axis_tvalid && s_axis_tready) begin
        mon_tick.command_valid = s_axis_tuser;
        mon_tick.target_mode   = s_axis_tdata[2:0];
        mon_tick.next_station  = s_axis_tdata[10:3];
        mon_tick.obstacle_seen = s_axis_tdata[11];
        expected_results.push_back(sequencer_tick(mon_tick));
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("[%0t] timeout with %0d results outstanding", $realtime,
               expected_results.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic push_tick(logic v, logic [2:0] tgt, logic [7:0] st, logic obs);
    rmsb_pkg::item_t it;
    it.command_valid = v;
    it.target_mode   = tgt;
    it.next_station  = st;
    it.obstacle_seen = obs;
    pending_ticks.push_back(it);
    queued_ticks++;
  endtask

  task automatic push_noise();
    push_tick(1'($urandom_range(1)), 3'($urandom_range(7)), 8'($urandom_range(255)),
              1'($urandom_range(1)));
  endtask

  task automatic write_reg(rmsb_pkg::cfg_idx_e idx, logic [9:0] val);
    int seen_before;
    seen_before = cfg_writes;
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index   <= idx;
    cfg_data_i  <= val;
    wait (cfg_writes != seen_before);
  endtask

  task automatic set_config(logic [9:0] dwell, logic [7:0] chk, logic [7:0] chg,
                            logic [7:0] trn);
    write_reg(rmsb_pkg::CFG_DWELL_TICKS, dwell);
    write_reg(rmsb_pkg::CFG_CHECK_BEEP_TICKS, {2'b0, chk});
    write_reg(rmsb_pkg::CFG_CHARGE_BEEP_TICKS, {2'b0, chg});
    write_reg(rmsb_pkg::CFG_TRANS_BEEP_TICKS, {2'b0, trn});
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // sender holds off until every tick in flight has its result
  task automatic drain();
    while (pending_ticks.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
      @(posedge clk_i);
  endtask

  // random mission fragments mixed with loose noise
  task automatic gen_missions(int count);
    int start;
    int k;
    int obs_run;
    start = queued_ticks;
    while (queued_ticks - start < count) begin
      case ($urandom_range(9))
        0, 1, 2: begin
          // checkpoint visit, then quiet ticks so the dwell can run out
          push_tick(1'b1, rmsb_pkg::MODE_CHECK, 8'($urandom_range(255)),
                    1'($urandom_range(1)));
          k = $urandom_range(1, 8);
          repeat (k) begin
            if ($urandom_range(5) == 0) push_noise();
            else push_tick(1'b0, 3'($urandom_range(7)), 8'($urandom_range(255)),
                           1'($urandom_range(1)));
          end
        end
        3, 4: begin
          // obstacle episode from line following or elsewhere
          if ($urandom_range(1))
            push_tick(1'b1, rmsb_pkg::MODE_LINE, 8'($urandom_range(255)), 1'b1);
          push_tick(1'b1, rmsb_pkg::MODE_OBST, 8'($urandom_range(255)), 1'b1);
          obs_run = $urandom_range(0, 6);
          repeat (obs_run) push_tick(1'($urandom_range(3) == 0), 3'($urandom_range(7)),
                                     8'($urandom_range(255)), 1'b1);
          push_tick(1'b0, 3'($urandom_range(7)), 8'($urandom_range(255)), 1'b0);
        end
        5: begin
          // charging session ending in idle
          push_tick(1'b1, rmsb_pkg::MODE_CHARGE, 8'($urandom_range(255)),
                    1'($urandom_range(1)));
          k = $urandom_range(0, 6);
          repeat (k) push_tick(1'b0, 3'($urandom_range(7)), 8'($urandom_range(255)),
                               1'($urandom_range(1)));
          push_tick(1'b1, rmsb_pkg::MODE_IDLE, 8'($urandom_range(255)),
                    1'($urandom_range(1)));
        end
        6: begin
          // emergency stop, refused commands, release to idle
          push_tick(1'b1, rmsb_pkg::MODE_ESTOP, 8'($urandom_range(255)),
                    1'($urandom_range(1)));
          k = $urandom_range(1, 4);
          repeat (k) push_tick(1'b1, 3'($urandom_range(1, 7)), 8'($urandom_range(255)),
                               1'($urandom_range(1)));
          push_tick(1'b1, rmsb_pkg::MODE_IDLE, 8'($urandom_range(255)),
                    1'($urandom_range(1)));
        end
        default: begin
          push_noise();
        end
      endcase
    end
  endtask

  // main sequence
  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed walk with reset register values, no idling
    push_tick(1'b0, rmsb_pkg::MODE_IDLE, 8'd0, 1'b0);
    push_tick(1'b1, rmsb_pkg::MODE_LINE, 8'd0, 1'b0);
    push_tick(1'b1, rmsb_pkg::MODE_LINE, 8'd85, 1'b0);    // same mode, no change
    push_tick(1'b1, 3'd6, 8'd255, 1'b0);                  // out-of-range target
    push_tick(1'b1, 3'd7, 8'd255, 1'b1);
    push_tick(1'b1, rmsb_pkg::MODE_OBST, 8'd0, 1'b1);     // obstacle from line
    push_tick(1'b0, rmsb_pkg::MODE_IDLE, 8'd0, 1'b1);     // obstacle held; alert runs out and re-arms
    push_tick(1'b0, rmsb_pkg::MODE_IDLE, 8'd0, 1'b1);
    push_tick(1'b0, rmsb_pkg::MODE_IDLE, 8'd0, 1'b0);     // falls back to line
    push_tick(1'b1, rmsb_pkg::MODE_CHECK, 8'd255, 1'b0);
    push_tick(1'b0, rmsb_pkg::MODE_CHECK, 8'd0, 1'b0);
    push_tick(1'b1, rmsb_pkg::MODE_CHARGE, 8'd17, 1'b0);
    push_tick(1'b0, rmsb_pkg::MODE_IDLE, 8'd0, 1'b0);
    push_tick(1'b1, rmsb_pkg::MODE_ESTOP, 8'd0, 1'b0);
    push_tick(1'b1, rmsb_pkg::MODE_LINE, 8'd0, 1'b1);     // refused in estop
    push_tick(1'b1, rmsb_pkg::MODE_CHARGE, 8'd0, 1'b0);
    push_tick(1'b1, rmsb_pkg::MODE_ESTOP, 8'd0, 1'b0);
    push_tick(1'b1, rmsb_pkg::MODE_IDLE, 8'd0, 1'b0);     // estop release
    push_tick(1'b1, rmsb_pkg::MODE_OBST, 8'd0, 1'b0);     // obstacle from idle, clear
    push_tick(1'b1, rmsb_pkg::MODE_CHECK, 8'd0, 1'b1);
    push_tick(1'b1, rmsb_pkg::MODE_OBST, 8'd0, 1'b1);     // obstacle from checkpoint
    push_tick(1'b0, rmsb_pkg::MODE_IDLE, 8'd0, 1'b0);     // back to idle
    push_tick(1'b1, rmsb_pkg::MODE_ESTOP, 8'd0, 1'b1);
    push_tick(1'b1, rmsb_pkg::MODE_IDLE, 8'd170, 1'b1);
    drain();

    // short dwell, zero and full beep lengths, no idling
    set_config(10'd3, 8'd0, 8'd255, 8'd1);
    gen_missions(90);
    drain();

    // longest dwell lets the kept dwell count build up; sender idles
    set_config(10'd1023, 8'd255, 8'd0, 8'd255);
    send_idle_pct = 46;
    gen_missions(80);
    drain();

    // dwell lowered to one ends the dwell at once; receiver stalls
    set_config(10'd1, 8'd7, 8'd3, 8'd0);
    send_idle_pct  = 0;
    recv_stall_pct = 46;
    gen_missions(80);
    drain();

    // dwell register zero; both sides idle
    set_config(10'd0, 8'd4, 8'd128, 8'd3);
    send_idle_pct  = 23;
    recv_stall_pct = 23;
    gen_missions(70);
    drain();

    // mid-range setting, no idling
    set_config(10'd5, 8'd2, 8'd9, 8'd4);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    gen_missions(70);
    drain();

    // back to the reset setting with both sides idling
    set_config(rmsb_pkg::DwellTicksRst, rmsb_pkg::CheckBeepRst, rmsb_pkg::ChargeBeepRst,
               rmsb_pkg::TransBeepRst);
    send_idle_pct  = 23;
    recv_stall_pct = 23;
    gen_missions(60);
    drain();

    repeat (10) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      $display("[%0t] %0d results never arrived", $realtime, expected_results.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
